FILE: hw/rtl/idrc_pkg.sv
`timescale 1ns / 1ps
// Package for the identifier-to-colour block: generator constants and the
// seed-word bundle passed from the seeding unit to the twist/temper unit.
// No dependencies.
package idrc_pkg;

    // Generator geometry
    localparam int MT_WORDS = 400;
    localparam int MT_SHIFT = 397;
    localparam int IDX_W    = $clog2(MT_WORDS);
    localparam int N_COLORS = 3;
    localparam int COLOR_W  = 8;
    localparam int WORD_W   = 32;

    // Seeding and twist constants
    localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908b0df;
    localparam logic [WORD_W-1:0] MT_UPPER    = 32'h80000000;
    localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fffffff;

    // Tempering masks
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc60000;

    // Seed words needed for the first three outputs: 0..3 and 397..399
    typedef struct packed {
        logic [N_COLORS:0][WORD_W-1:0]   lo;
        logic [N_COLORS-1:0][WORD_W-1:0] hi;
    } t_seed_words;

    typedef logic [N_COLORS-1:0][COLOR_W-1:0] t_colors;

endpackage

FILE: hw/rtl/idrc_seed.sv
`timescale 1ns / 1ps
// Seeding unit: one shared 32x32 multiplier walks the MT19937 seed recurrence
// from word 1 to word 399, keeping words 0..3 and 397..399.
// Depends on idrc_pkg.
module idrc_seed (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [idrc_pkg::WORD_W-1:0]       i_seed,
    output logic                              o_done,
    output idrc_pkg::t_seed_words             o_words
);

    localparam logic [idrc_pkg::IDX_W-1:0] LAST_IDX  = idrc_pkg::IDX_W'(idrc_pkg::MT_WORDS - 1);
    localparam logic [idrc_pkg::IDX_W-1:0] HI_FIRST  = idrc_pkg::IDX_W'(idrc_pkg::MT_SHIFT);
    localparam logic [idrc_pkg::IDX_W-1:0] LO_LIMIT  = idrc_pkg::IDX_W'(idrc_pkg::N_COLORS + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [idrc_pkg::IDX_W-1:0]    r_idx;
    logic [idrc_pkg::WORD_W-1:0]   r_prev;
    idrc_pkg::t_seed_words         r_words;

    logic [idrc_pkg::WORD_W-1:0]   w_mix;
    logic [idrc_pkg::WORD_W-1:0]   n_word;
    logic [idrc_pkg::IDX_W-1:0]    w_hi_off;

    // One recurrence step: (p ^ p>>30) * K + i, modulo 2^32
    assign w_mix    = r_prev ^ (r_prev >> 30);
    assign n_word   = idrc_pkg::WORD_W'(w_mix * idrc_pkg::MT_INIT_MUL)
                    + idrc_pkg::WORD_W'(r_idx);
    assign w_hi_off = r_idx - HI_FIRST;

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= idrc_pkg::IDX_W'(1);
            end else if (r_busy) begin
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Running word and the kept words
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prev       <= i_seed;
            r_words.lo[0] <= i_seed;
        end else if (r_busy) begin
            r_prev <= n_word;
            if (r_idx < LO_LIMIT) begin
                r_words.lo[r_idx[1:0]] <= n_word;
            end
            if (r_idx >= HI_FIRST) begin
                r_words.hi[w_hi_off[1:0]] <= n_word;
            end
        end
    end

    assign o_done  = r_done;
    assign o_words = r_words;

endmodule

FILE: hw/rtl/idrc_mix.sv
`timescale 1ns / 1ps
// Twist and temper unit: one shared twist/temper path produces the three
// colour bytes, one per cycle, from the kept seed words.
// Depends on idrc_pkg.
module idrc_mix (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  idrc_pkg::t_seed_words  i_words,
    output logic                   o_done,
    output idrc_pkg::t_colors      o_colors
);

    localparam logic [1:0] LAST_STEP = 2'(idrc_pkg::N_COLORS - 1);

    function automatic logic [idrc_pkg::WORD_W-1:0] temper(
        input logic [idrc_pkg::WORD_W-1:0] x
    );
        logic [idrc_pkg::WORD_W-1:0] y;
        begin
            y = x ^ (x >> 11);
            y = y ^ ((y << 7) & idrc_pkg::TEMPER_B);
            y = y ^ ((y << 15) & idrc_pkg::TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        end
    endfunction

    logic                        r_busy;
    logic                        r_done;
    logic [1:0]                  r_step;
    idrc_pkg::t_seed_words       r_words;
    idrc_pkg::t_colors           r_colors;

    logic [idrc_pkg::WORD_W-1:0] w_y;
    logic [idrc_pkg::WORD_W-1:0] w_twist;
    logic [idrc_pkg::WORD_W-1:0] w_temp;

    // Twist on the words at the head of the shift line, then temper
    assign w_y     = (r_words.lo[0] & idrc_pkg::MT_UPPER) | (r_words.lo[1] & idrc_pkg::MT_LOWER);
    assign w_twist = r_words.hi[0] ^ (w_y >> 1) ^ (w_y[0] ? idrc_pkg::MT_MATRIX : '0);
    assign w_temp  = temper(w_twist);

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Words shift down one place per step; bytes shift in from the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_words <= i_words;
        end else if (r_busy) begin
            r_words.lo <= {idrc_pkg::WORD_W'(0), r_words.lo[idrc_pkg::N_COLORS:1]};
            r_words.hi <= {idrc_pkg::WORD_W'(0), r_words.hi[idrc_pkg::N_COLORS-1:1]};
            r_colors   <= {w_temp[idrc_pkg::COLOR_W-1:0],
                           r_colors[idrc_pkg::N_COLORS-1:1]};
        end
    end

    assign o_done   = r_done;
    assign o_colors = r_colors;

endmodule

FILE: hw/rtl/id_to_random_color.sv
`timescale 1ns / 1ps
// Top level of the identifier-to-colour block: sequencer, output register.
// Depends on idrc_pkg, idrc_seed and idrc_mix.
//
// Turns a signed 32-bit face identifier into a reproducible colour: a negative
// identifier gives black with o_is_background set; otherwise the identifier
// seeds MT19937 and the low bytes of its first three tempered outputs give red,
// green and blue. One item is handled at a time. A foreground item passes
// through 399 seed steps on the single 32x32 seeding multiplier, a hand-over
// of the kept words, three twist/temper steps, the exit from the mix state and
// the output load, which waits while the consumer stalls a held result; a
// background item goes straight to the output load. o_stall is high while
// an item is in progress and drops the cycle after its result is loaded, so
// a new item is accepted only after the last one's result has been loaded.
// The output register lets a result wait for the consumer while the next item
// is already accepted and worked on.
module id_to_random_color (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_face_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_is_background
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_bg;
    logic                  r_out_valid;
    logic [7:0]            r_red;
    logic [7:0]            r_green;
    logic [7:0]            r_blue;
    logic                  r_out_bg;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_load;
    logic                  w_seed_start;
    logic                  w_seed_done;
    logic                  w_mix_done;
    idrc_pkg::t_seed_words w_words;
    idrc_pkg::t_colors     w_colors;

    // Handshake
    assign w_accept     = i_valid && (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_load       = (r_state == ST_HOLD) && w_out_free;
    assign w_seed_start = w_accept && !i_face_id[31];

    // Seeding and twist/temper units
    idrc_seed u_seed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_seed_start),
        .i_seed  (i_face_id),
        .o_done  (w_seed_done),
        .o_words (w_words)
    );

    idrc_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_seed_done),
        .i_words  (w_words),
        .o_done   (w_mix_done),
        .o_colors (w_colors)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = i_face_id[31] ? ST_HOLD : ST_SEED;
            ST_SEED: if (w_seed_done) n_state = ST_MIX;
            ST_MIX:  if (w_mix_done) n_state = ST_HOLD;
            ST_HOLD: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item flag and output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bg <= i_face_id[31];
        end
        if (w_load) begin
            r_out_bg <= r_bg;
            r_red    <= r_bg ? 8'd0 : w_colors[0];
            r_green  <= r_bg ? 8'd0 : w_colors[1];
            r_blue   <= r_bg ? 8'd0 : w_colors[2];
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_is_background = r_out_bg;

`ifndef ASSERT_OFF
    // Seeding finishes only while the sequencer waits for it
    a_seed_done_in_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seed_done |-> (r_state == ST_SEED))
        else $error("seed unit finished outside seeding state");

    // Twist/temper finishes only while the sequencer waits for it
    a_mix_done_in_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix_done |-> (r_state == ST_MIX))
        else $error("mix unit finished outside mix state");

    // A background result is black
    a_bg_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_background) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("background item with non-zero colour");

    // An accepted item leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting an item");
`endif

endmodule
